[hdl/kgr_pkg.sv]
package kgr_pkg;

   localparam int MAX_GROUP = 16;
   localparam int DATA_W    = 32;
   localparam int CFG_W     = 5;
   localparam int CNT_W     = $clog2(MAX_GROUP + 1);
   localparam int ADDR_W    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

   localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = CFG_W'(3);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic accept;
      logic rd;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic out_last;
   } status_type;

   function automatic logic [CNT_W-1:0] eff_size(input logic [CFG_W-1:0] gs);
      logic [CNT_W-1:0] g;
      if (gs == '0) begin
         g = CNT_W'(1);
      end else if (int'(gs) > MAX_GROUP) begin
         g = CNT_W'(MAX_GROUP);
      end else begin
         g = CNT_W'(gs);
      end
      return g;
   endfunction

endpackage

[hdl/kgr_req_if.sv]
interface kgr_req_if;
   import kgr_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] value;
   logic                     end_of_list;

   modport source (output valid, output value, output end_of_list, input ready);
   modport sink   (input valid, input value, input end_of_list, output ready);
endinterface

[hdl/kgr_rsp_if.sv]
interface kgr_rsp_if;
   import kgr_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] out_value;
   logic                     run_last;
   logic                     list_done;

   modport source (output valid, output out_value, output run_last, output list_done,
                   input ready);
   modport sink   (input valid, input out_value, input run_last, input list_done,
                   output ready);
endinterface

[hdl/kgr_ram.sv]
module kgr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/kgr_datapath.sv]
module kgr_datapath
   import kgr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CFG_W-1:0]         csr_write_data,
   input  logic signed [DATA_W-1:0] in_value,
   input  logic                     in_end_of_list,
   input  cmd_type                  cmd,
   output status_type               status,
   output logic signed [DATA_W-1:0] out_value,
   output logic                     out_run_last,
   output logic                     out_list_done
);

   logic [CFG_W-1:0]  group_size_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [CNT_W-1:0]  idx_ff;
   logic [CNT_W-1:0]  idx_in;
   logic              reverse_ff;
   logic              eol_ff;
   logic              last_ff;
   logic [CNT_W-1:0]  size;
   logic [CNT_W-1:0]  count_next;
   logic              full;
   logic [CNT_W-1:0]  rd_pos;
   logic [DATA_W-1:0] rd_data;
   logic              wr_en;

   assign size       = eff_size(group_size_ff);
   assign count_next = count_ff + CNT_W'(1);
   assign full       = (count_next >= size);
   assign wr_en      = cmd.accept && (int'(count_ff) < MAX_GROUP);
   assign rd_pos     = reverse_ff ? (count_ff - CNT_W'(1) - idx_ff) : idx_ff;

   assign status.emit     = full || in_end_of_list;
   assign status.out_last = last_ff;

   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      if (cmd.accept) begin
         count_in = count_next;
         idx_in   = '0;
      end
      if (cmd.rd) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (cmd.finish) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= GROUP_SIZE_RESET;
         count_ff      <= '0;
         idx_ff        <= '0;
         last_ff       <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            group_size_ff <= csr_write_data;
         end
         count_ff <= count_in;
         idx_ff   <= idx_in;
         if (cmd.rd) begin
            last_ff <= (idx_ff == count_ff - CNT_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         reverse_ff <= full;
         eol_ff     <= in_end_of_list;
      end
   end

   kgr_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_GROUP)
   ) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (in_value),
      .rd_en   (cmd.rd),
      .rd_addr (rd_pos[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign out_value     = rd_data;
   assign out_run_last  = last_ff;
   assign out_list_done = last_ff && eol_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= MAX_GROUP)
      else $error("held count out of range");

   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> (int'(count_ff) < MAX_GROUP))
      else $error("value accepted with full buffer");

   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |-> (idx_ff < count_ff))
      else $error("read beyond held values");

endmodule

[hdl/kgr_ctrl.sv]
module kgr_ctrl
   import kgr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   output logic       out_valid,
   input  logic       out_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      in_ready   = 1'b0;
      out_valid  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.accept = 1'b1;
               if (status.emit) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            out_valid = 1'b1;
            if (out_ready) begin
               if (status.out_last) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  cmd.rd = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_emit_starts_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && in_valid && status.emit) |=> (state_ff == ST_READ))
      else $error("emitting transfer did not start drain");

   a_read_then_send: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_SEND))
      else $error("read not followed by send");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.accept && (cmd.rd || cmd.finish)))
      else $error("accept overlaps drain");

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (state_ff == ST_IDLE))
      else $error("finish did not return to idle");

endmodule

[hdl/k_group_reverser_top.sv]
// An item that ends a group or the list moves the block to ST_READ (buffer read),
// then ST_SEND, which offers results one per cycle while rsp is ready.
// Items that complete nothing are taken one per cycle; an item that emits n
// values runs accept, buffer read and n result transfers, with no new item taken.
// Reset: synchronous, active high; clears the held count, returns group_size to 3.
module k_group_reverser_top
   import kgr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   kgr_req_if.sink          req_chan,
   kgr_rsp_if.source        rsp_chan,
   input  logic             csr_write_enable,
   input  logic [CFG_W-1:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;

   kgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   kgr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .in_value         (req_chan.value),
      .in_end_of_list   (req_chan.end_of_list),
      .cmd              (cmd),
      .status           (status),
      .out_value        (rsp_chan.out_value),
      .out_run_last     (rsp_chan.run_last),
      .out_list_done    (rsp_chan.list_done)
   );

endmodule
